FILE: rtl/lns16_pkg.sv
package lns16_pkg;

  // correction table size, entries for d = 0 .. TABLE_DEPTH-1
  localparam int TABLE_DEPTH = 16384;
  localparam int ROM_AW = $clog2(TABLE_DEPTH);
  localparam logic [15:0] TABLE_LIMIT = 16'(TABLE_DEPTH);

  localparam logic [15:0] ZERO_CODE = 16'h8000;

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TWO_Q62 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef logic signed [15:0] rom_t [TABLE_DEPTH];

  // fixed-point helpers, evaluated once at time zero to fill the table

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // e^-x in Q62 by alternating taylor series
  function automatic logic [63:0] exp_neg(input logic [63:0] x);
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] term;
    logic        done;
    plus  = ONE_Q62;
    minus = 64'd0;
    term  = ONE_Q62;
    done  = 1'b0;
    for (int k = 1; k <= 30; k++) begin
      if (!done) begin
        term = qmul(term, x) / 64'(k);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k % 2 == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
    end
    return plus - minus;
  endfunction

  // log2 of a positive Q62 value as signed Q52
  function automatic logic signed [63:0] log2_q52(input logic [63:0] m_in);
    logic [63:0]        m;
    logic [63:0]        f;
    logic [63:0]        y;
    logic signed [63:0] e;
    m = m_in;
    e = 64'sd0;
    f = 64'd0;
    for (int i = 0; i < 64; i++) begin
      if (m >= TWO_Q62) begin
        m = m >> 1;
        e = e + 64'sd1;
      end
    end
    for (int i = 0; i < 64; i++) begin
      if (m < ONE_Q62) begin
        m = m << 1;
        e = e - 64'sd1;
      end
    end
    y = m;
    for (int i = 0; i < 52; i++) begin
      y = qmul(y, y);
      f = f << 1;
      if (y >= TWO_Q62) begin
        y = y >> 1;
        f = f | 64'd1;
      end
    end
    return (e <<< 52) + $signed(f);
  endfunction

  // round(1024 * log2(1 +/- 2^(-d/1024)))
  function automatic logic signed [15:0] correction(input int d, input logic differ);
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        u;
    logic [63:0]        m;
    logic [63:0]        mag;
    logic signed [63:0] l;
    if (d >= TABLE_DEPTH) begin
      return 16'sd0;
    end
    q = 64'((d >> 10) & 31);
    r = 64'(d & 1023);
    x = (LN2_Q64 >> 12) * r + (((LN2_Q64 & 64'hFFF) * r) >> 12);
    u = exp_neg(x) >> q;
    m = differ ? ONE_Q62 - u : ONE_Q62 + u;
    if (m == 64'd0) begin
      return 16'sd0;
    end
    l = log2_q52(m);
    if (l >= 64'sd0) begin
      mag = ($unsigned(l) + (64'd1 << 41)) >> 42;
      return $signed(mag[15:0]);
    end
    mag = ($unsigned(-l) + (64'd1 << 41)) >> 42;
    return -$signed(mag[15:0]);
  endfunction

endpackage

FILE: rtl/lns16_arithmetic_unit_top.sv
// channel   | valid     | ready     | payload
// ----------+-----------+-----------+-------------------------------------
// request   | in_valid  | in_ready  | command, operand_a, operand_b
// result    | out_valid | out_ready | result, div_by_zero
//
// three register stages: decode and special cases, correction rom read, final add
// one request per cycle sustained while out_ready stays high; a request passes the decode, rom read
// and output registers in that order, and out_valid rises when it reaches the output register
// the rom's registered read port sets the middle stage
// rst clears only the stage valid bits; payload registers are not reset
// each stage holds when the next one is full and stalled, so bubbles collapse
module lns16_arithmetic_unit_top
  import lns16_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [15:0] operand_a,
  input  logic signed [15:0] operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result,
  output logic               div_by_zero
);

  // stage enables, each stage moves when empty or when the next one moves
  logic en1;
  logic en2;
  logic en3;

  logic v1;
  logic v2;
  logic v3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // ---------------- stage 1: decode ----------------
  cmd_t               cmd;
  logic [15:0]        a;
  logic [15:0]        b;
  logic [15:0]        b_eff;
  logic               za;
  logic               zb;
  logic signed [15:0] la;
  logic signed [15:0] lb;
  logic signed [15:0] diff;
  logic [14:0]        d;
  logic               d_in_range;
  logic               special_next;
  logic [15:0]        spec_res_next;
  logic               dz_next;
  logic [15:0]        big_next;
  logic               differ_next;

  assign cmd   = cmd_t'(command);
  assign a     = operand_a;
  assign b     = operand_b;
  // subtract is add of the sign-flipped second operand
  assign b_eff = (cmd == CMD_SUB) ? (b ^ 16'h0001) : b;

  // zero codes are 0x8000 and 0x8001
  assign za = (a[15:1] == 15'h4000);
  assign zb = (b[15:1] == 15'h4000);

  // log parts, 15-bit signed, widened for the difference
  assign la   = {a[15], a[15:1]};
  assign lb   = {b_eff[15], b_eff[15:1]};
  assign diff = la - lb;
  assign d    = diff[15] ? 15'(-diff) : diff[14:0];
  assign d_in_range = ({1'b0, d} < TABLE_LIMIT);

  assign big_next    = ($signed(a) >= $signed(b_eff)) ? a : b_eff;
  assign differ_next = a[0] ^ b_eff[0];

  always_comb begin
    special_next  = 1'b1;
    spec_res_next = ZERO_CODE;
    dz_next       = 1'b0;
    unique case (cmd)
      CMD_ADD, CMD_SUB: begin
        priority if (za) begin
          spec_res_next = b_eff;
        end else if (zb) begin
          spec_res_next = a;
        end else if ((a ^ 16'h0001) == b_eff) begin
          // exact cancellation
          spec_res_next = ZERO_CODE;
        end else begin
          special_next = 1'b0;
        end
      end
      CMD_MUL: begin
        if (za || zb) begin
          spec_res_next = ZERO_CODE;
        end else begin
          spec_res_next = (a + b - {15'd0, b[0]}) ^ {15'd0, b[0]};
        end
      end
      CMD_DIV: begin
        priority if (za) begin
          spec_res_next = ZERO_CODE;
        end else if (zb) begin
          spec_res_next = ZERO_CODE;
          dz_next       = 1'b1;
        end else begin
          spec_res_next = (a - b + {15'd0, b[0]}) ^ {15'd0, b[0]};
        end
      end
      default: begin
        spec_res_next = ZERO_CODE;
      end
    endcase
  end

  logic              s1_special;
  logic [15:0]       s1_spec_res;
  logic              s1_dz;
  logic [15:0]       s1_big;
  logic              s1_differ;
  logic              s1_in_range;
  logic [ROM_AW-1:0] s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_special  <= special_next;
      s1_spec_res <= spec_res_next;
      s1_dz       <= dz_next;
      s1_big      <= big_next;
      s1_differ   <= differ_next;
      s1_in_range <= d_in_range;
      // out-of-table differences read entry 0, the value is dropped later
      s1_addr     <= d_in_range ? d[ROM_AW-1:0] : '0;
    end
  end

  // ---------------- stage 2: correction lookup ----------------
  logic signed [15:0] corr;
  logic               s2_special;
  logic [15:0]        s2_spec_res;
  logic               s2_dz;
  logic [15:0]        s2_big;
  logic               s2_in_range;

  lns16_corr_rom u_rom (
    .clk    (clk),
    .en     (en2),
    .addr   (s1_addr),
    .differ (s1_differ),
    .corr   (corr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_special  <= s1_special;
      s2_spec_res <= s1_spec_res;
      s2_dz       <= s1_dz;
      s2_big      <= s1_big;
      s2_in_range <= s1_in_range;
    end
  end

  // ---------------- stage 3: final add, output register ----------------
  logic [15:0] sum;

  // twice the correction added to the larger code, wrapping mod 2^16
  assign sum = s2_big + (s2_in_range ? {corr[14:0], 1'b0} : 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result      <= s2_special ? s2_spec_res : sum;
      div_by_zero <= s2_dz;
    end
  end

  assign out_valid = v3;

endmodule

FILE: rtl/lns16_corr_rom.sv
module lns16_corr_rom
  import lns16_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [ROM_AW-1:0]        addr,
  input  logic                     differ,
  output logic signed [15:0]       corr
);

  rom_t plus_rom;
  rom_t minus_rom;

  logic signed [15:0] plus_q;
  logic signed [15:0] minus_q;
  logic               differ_q;

  // table contents worked out once at time zero
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      plus_rom[i]  = correction(i, 1'b0);
      minus_rom[i] = correction(i, 1'b1);
    end
  end

  // registered reads, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      plus_q   <= plus_rom[addr];
      minus_q  <= minus_rom[addr];
      differ_q <= differ;
    end
  end

  assign corr = differ_q ? minus_q : plus_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import lns16_pkg::*;
();

  // fixed-point constants for the correction word, Q62 unless named otherwise
  localparam logic [63:0] UNIT_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PAIR_Q62 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LN2_Q64F = 64'hB172_17F7_D1CF_79AC;

  // receiver hold-off length used to fill the pipe and back up the request side
  localparam int LONG_STALL = 150;

  // one result as seen on the result channel
  typedef struct packed {
    logic [15:0] code;
    logic        dbz;
  } lns_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_ADD;
  logic [15:0] operand_a = 16'd0;
  logic [15:0] operand_b = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result;
  logic        div_by_zero;

  // results predicted for accepted requests, oldest first
  lns_out_t expected_results[$];
  // correction words already worked out, keyed by 2*d + sign-differ
  logic signed [15:0] corr_cache[int];

  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_receiver = 1'b0;
  int  stall_count = 0;

  lns16_arithmetic_unit_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result),
    .div_by_zero(div_by_zero)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the pipe hangs
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // unsigned Q62 product, truncated
  function automatic logic [63:0] q62_product(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] full;
    full = {64'd0, x} * {64'd0, y};
    return 64'(full >> 62);
  endfunction

  // e^-x by alternating taylor terms; running sum wraps like the plus/minus pair
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = UNIT_Q62;
    term = UNIT_Q62;
    for (int k = 1; k <= 30 && term != 64'd0; k++) begin
      term = q62_product(term, x) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // log2 of a positive Q62 value, result in signed Q52
  function automatic logic signed [63:0] log2_q52_of(input logic [63:0] m);
    logic signed [63:0] expo;
    logic [63:0]        frac;
    expo = 64'sd0;
    frac = 64'd0;
    while (m >= PAIR_Q62) begin
      m    = m >> 1;
      expo = expo + 64'sd1;
    end
    while (m < UNIT_Q62) begin
      m    = m << 1;
      expo = expo - 64'sd1;
    end
    // one fraction bit per squaring
    for (int i = 0; i < 52; i++) begin
      m    = q62_product(m, m);
      frac = {frac[62:0], 1'b0};
      if (m >= PAIR_Q62) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return expo * (64'sd1 <<< 52) + $signed(frac);
  endfunction

  // round(1024 * log2(1 +/- 2^(-d/1024))), zero past the end of the table
  function automatic logic signed [15:0] log_correction(input int d, input logic differ);
    int                 key;
    logic [63:0]        shift_q;
    logic [63:0]        rem;
    logic [63:0]        x;
    logic [63:0]        u;
    logic [63:0]        m;
    logic [63:0]        mag;
    logic signed [63:0] l;
    logic signed [15:0] c;
    key = d * 2 + int'(differ);
    if (corr_cache.exists(key)) begin
      return corr_cache[key];
    end
    c = 16'sd0;
    if (d < TABLE_DEPTH) begin
      shift_q = 64'((d >> 10) & 31);
      rem     = 64'(d & 1023);
      x = (LN2_Q64F >> 12) * rem + (((LN2_Q64F & 64'hFFF) * rem) >> 12);
      u = exp_neg_q62(x) >> shift_q;
      m = differ ? UNIT_Q62 - u : UNIT_Q62 + u;
      if (m != 64'd0) begin
        l = log2_q52_of(m);
        // round half away from zero at 2^-42
        if (l >= 64'sd0) begin
          mag = (64'(l) + (64'd1 << 41)) >> 42;
          c   = $signed(mag[15:0]);
        end else begin
          mag = (64'(-l) + (64'd1 << 41)) >> 42;
          c   = -$signed(mag[15:0]);
        end
      end
    end
    corr_cache[key] = c;
    return c;
  endfunction

  function automatic logic is_zero_code(input logic [15:0] v);
    return (v | 16'd1) == 16'h8001;
  endfunction

  // log-domain sum of two codes
  function automatic logic [15:0] lns_sum(input logic [15:0] a, input logic [15:0] b);
    logic [15:0]        larger;
    int                 log_a;
    int                 log_b;
    int                 span;
    logic signed [15:0] c;
    if (is_zero_code(a)) begin
      return b;
    end
    if (is_zero_code(b)) begin
      return a;
    end
    // x plus its negation
    if ((a ^ 16'd1) == b) begin
      return ZERO_CODE;
    end
    larger = ($signed(a) >= $signed(b)) ? a : b;
    log_a  = int'($signed(a)) >>> 1;
    log_b  = int'($signed(b)) >>> 1;
    span   = log_a - log_b;
    if (span < 0) begin
      span = -span;
    end
    c = log_correction(span, a[0] ^ b[0]);
    return larger + {c[14:0], 1'b0};
  endfunction

  function automatic lns_out_t predict_lns_op(input cmd_t op, input logic [15:0] a,
                                              input logic [15:0] b);
    lns_out_t    r;
    logic [15:0] sb;
    sb     = {15'd0, b[0]};
    r.code = ZERO_CODE;
    r.dbz  = 1'b0;
    case (op)
      CMD_ADD: begin
        r.code = lns_sum(a, b);
      end
      CMD_SUB: begin
        r.code = lns_sum(a, b ^ 16'd1);
      end
      CMD_MUL: begin
        if (!is_zero_code(a) && !is_zero_code(b)) begin
          r.code = (a + b - sb) ^ sb;
        end
      end
      default: begin
        // zero dividend wins over zero divisor
        if (is_zero_code(a)) begin
          r.code = ZERO_CODE;
        end else if (is_zero_code(b)) begin
          r.dbz = 1'b1;
        end else begin
          r.code = (a - b + sb) ^ sb;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, random idle cycles first, return at the accepting edge
  task automatic send_request(input cmd_t op, input logic [15:0] a, input logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_results.push_back(predict_lns_op(op, a, b));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // mostly random codes, sometimes one of the two zero codes
  function automatic logic [15:0] random_code();
    if ($urandom_range(99) < 6) begin
      return ZERO_CODE | 16'($urandom_range(1));
    end
    return 16'($urandom);
  endfunction

  // second operand: exact negation, a close neighbor (small d, near the start of the rom) or random
  function automatic logic [15:0] random_partner(input logic [15:0] a);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return a ^ 16'd1;
    end
    if (pick < 45) begin
      return (a + 16'($urandom_range(4095)) - 16'd2048) ^ 16'($urandom_range(1));
    end
    return random_code();
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random ready, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (hold_receiver && stall_count < LONG_STALL) begin
      out_ready   <= 1'b0;
      stall_count <= stall_count + 1;
    end else begin
      if (!hold_receiver) begin
        stall_count <= 0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    lns_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result %h dbz %b", result, div_by_zero);
        end
      end else begin
        want = expected_results.pop_front();
        if (result !== want.code || div_by_zero !== want.dbz) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected %h dbz %b, got %h dbz %b",
                     want.code, want.dbz, result, div_by_zero);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // multiply and divide: wrap, signs, zero codes, divide by zero
  task automatic test_mul_div_cases();
    send_request(CMD_MUL, 16'h0000, 16'h0000);
    send_request(CMD_MUL, 16'h7FFE, 16'h7FFE);   // log part wraps
    send_request(CMD_MUL, 16'h0003, 16'h0005);   // two negatives
    send_request(CMD_MUL, 16'h8001, 16'h1234);   // zero times x
    send_request(CMD_MUL, 16'h1234, 16'h8000);
    send_request(CMD_DIV, 16'h0400, 16'h0800);
    send_request(CMD_DIV, 16'h8002, 16'h7FFF);   // extremes, wraps
    send_request(CMD_DIV, 16'h8000, 16'h8001);   // zero by zero, no flag
    send_request(CMD_DIV, 16'h1235, 16'h8000);   // divide by zero, flag
    send_request(CMD_DIV, 16'hFFFF, 16'h0001);
    drain_results();
  endtask

  // add and subtract: zero operands, cancellation, table edges, overflow
  task automatic test_add_sub_cases();
    send_request(CMD_ADD, 16'h8000, 16'h1235);   // zero plus x
    send_request(CMD_ADD, 16'h4322, 16'h8001);   // x plus zero
    send_request(CMD_SUB, 16'h8000, 16'h1234);   // zero minus x gives -x
    send_request(CMD_ADD, 16'h2468, 16'h2469);   // exact cancellation
    send_request(CMD_SUB, 16'h2468, 16'h2468);
    send_request(CMD_ADD, 16'h0800, 16'h0800);   // equal logs, same sign
    send_request(CMD_SUB, 16'h0800, 16'h0802);   // d of one, signs differ
    send_request(CMD_ADD, 16'h0000, 16'h8002);   // last table entry
    send_request(CMD_ADD, 16'h0002, 16'h8002);   // just past the table
    send_request(CMD_ADD, 16'h7FFE, 16'h8002);   // largest difference
    send_request(CMD_ADD, 16'h7FFF, 16'h7FFF);   // sum wraps
    send_request(CMD_SUB, 16'hFFFF, 16'h0000);
    send_request(CMD_ADD, 16'h8003, 16'h8004);
    send_request(CMD_DIV, 16'h8001, 16'h8000);
    drain_results();
  endtask

  // receiver holds off while requests keep coming, so the pipe fills and stalls
  task automatic test_output_stall();
    send_idle_pct = 0;
    hold_receiver <= 1'b1;
    repeat (24) begin
      send_request(cmd_t'($urandom_range(3)), random_code(), random_code());
    end
    // the hold-off has run its count by the time the last requests get in
    drain_results();
    hold_receiver <= 1'b0;
  endtask

  // random requests with the given idle rates on both sides
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [15:0] a;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    repeat (count) begin
      a = random_code();
      send_request(cmd_t'($urandom_range(3)), a, random_partner(a));
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct <= 20;
    test_mul_div_cases();
    test_add_sub_cases();
    test_output_stall();
    test_random_traffic(370, 33, 83);
    test_random_traffic(370, 83, 33);
    test_random_traffic(370, 0, 0);
    // leave room for anything stray
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
